@@ src/ittp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ittp_pkg
// Shared types, codes and helpers for the infix-to-postfix token reorder core.
// ----------------------------------------------------------------------------
package ittp_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [5:0]        entry_t;

  localparam addr_t STACK_CAP = addr_t'(STACK_DEPTH - 1);

  // input token kinds
  localparam logic [2:0] KIND_NUMBER = 3'd0;
  localparam logic [2:0] KIND_WORD   = 3'd1;
  localparam logic [2:0] KIND_OPER   = 3'd2;
  localparam logic [2:0] KIND_LPAREN = 3'd3;
  localparam logic [2:0] KIND_RPAREN = 3'd4;
  localparam logic [2:0] KIND_END    = 3'd5;

  // result kinds
  localparam logic [2:0] OUT_NUMBER = 3'd0;
  localparam logic [2:0] OUT_WORD   = 3'd1;
  localparam logic [2:0] OUT_OPER   = 3'd2;
  localparam logic [2:0] OUT_ERROR  = 3'd3;
  localparam logic [2:0] OUT_END    = 3'd4;

  localparam logic [2:0] OP_MINUS = 3'd1;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_POWER = 3'd4;

  localparam logic [3:0] WORD_OTHER = 4'd11;

  localparam entry_t ENTRY_OP     = 6'd16;
  localparam entry_t ENTRY_LPAREN = 6'd32;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  op;
    logic [3:0]  word;
    logic [31:0] number;
  } item_t;

  typedef struct packed {
    logic   wr_en;
    addr_t  wr_addr;
    entry_t wr_data;
    logic   rd_en;
    addr_t  rd_addr;
  } stack_req_t;

  function automatic logic [2:0] entry_prec(entry_t e);
    logic [2:0] p;
    if (e == ENTRY_LPAREN) begin
      p = 3'd0;
    end else if (e >= ENTRY_OP) begin
      if (e[2:0] <= OP_MINUS)    p = 3'd1;
      else if (e[2:0] <= OP_DIV) p = 3'd2;
      else                       p = 3'd3;
    end else if (e < entry_t'(WORD_OTHER)) begin
      p = 3'd4;
    end else begin
      p = 3'd0;
    end
    return p;
  endfunction

  function automatic item_t entry_item(entry_t e);
    item_t it;
    it = '0;
    if (e >= ENTRY_OP) begin
      it.kind = OUT_OPER;
      it.op   = e[2:0];
    end else begin
      it.kind = OUT_WORD;
      it.word = e[3:0];
    end
    return it;
  endfunction

endpackage

@@ src/ittp_stack_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ittp_stack_ram
// Operator stack storage: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ittp_stack_ram (
  input  logic                clk,
  input  ittp_pkg::stack_req_t req,
  output ittp_pkg::entry_t     rd_data
);
  import ittp_pkg::*;

  entry_t mem [STACK_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/infix_to_postfix_token_reorder_core.sv @@
`timescale 1ns / 1ps
// A number item is registered in pend and then moved into the output register.
// The core takes one token at a time (in_tready is high only in S_IDLE); each stack
//   entry removed takes a read and a check state; the stack read is registered.
// A stalled output holds the engine when an item is made while another is pending,
//   and in S_FLUSH while the pending item waits to move to the output.
// Reset (rst_n low, synchronous) empties the stack and drops any pending item.
// ----------------------------------------------------------------------------
// infix_to_postfix_token_reorder_core
// Shunting-yard reorder of lexed infix tokens into postfix order.
// ----------------------------------------------------------------------------
module infix_to_postfix_token_reorder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op_code[2:0], word_id[6:3], number_bits[38:7]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_op[2:0], out_word[6:3], out_number[38:7]
  output logic [2:0]  out_tuser,  // out_kind[2:0]
  output logic        out_tlast
);
  import ittp_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PUSH, S_POP_RD, S_POP_CHK, S_FLUSH} state_t;
  typedef enum logic [1:0] {M_OPER, M_RPAREN, M_END} mode_t;

  state_t     state_r, state_nxt;
  mode_t      mode_r, mode_nxt;
  addr_t      count_r, count_nxt;
  entry_t     entry_r, entry_nxt;
  item_t      pend_r, pend_nxt;
  logic       pend_v_r, pend_v_nxt;
  item_t      out_item_r, out_item_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_last_r, out_last_nxt;

  stack_req_t req;
  entry_t     top;
  logic       ofree, can_put, put;
  item_t      put_item;
  logic [2:0] cur_prec, top_prec;
  logic       pops;
  logic [2:0] in_op;
  logic [3:0] in_word;

  ittp_stack_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (top)
  );

  assign in_op   = in_tdata[2:0];
  assign in_word = in_tdata[6:3];

  assign ofree    = !out_valid_r || out_tready;
  assign can_put  = !pend_v_r || ofree;
  assign cur_prec = entry_prec(entry_r);
  assign top_prec = entry_prec(top);
  assign pops     = (top_prec > cur_prec) ||
                    ((top_prec == cur_prec) && (entry_r[2:0] != OP_POWER));

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    entry_nxt     = entry_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    req           = '0;
    put           = 1'b0;
    put_item      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            KIND_NUMBER: begin
              put             = 1'b1;
              put_item.kind   = OUT_NUMBER;
              put_item.number = in_tdata[38:7];
              state_nxt       = S_FLUSH;
            end
            KIND_WORD: begin
              entry_nxt = {2'b00, (in_word > WORD_OTHER) ? WORD_OTHER : in_word};
              state_nxt = S_PUSH;
            end
            KIND_OPER: begin
              if (in_op <= OP_POWER) begin
                entry_nxt = ENTRY_OP + entry_t'(in_op);
                mode_nxt  = M_OPER;
                state_nxt = S_POP_RD;
              end
            end
            KIND_LPAREN: begin
              entry_nxt = ENTRY_LPAREN;
              state_nxt = S_PUSH;
            end
            KIND_RPAREN: begin
              mode_nxt  = M_RPAREN;
              state_nxt = S_POP_RD;
            end
            KIND_END: begin
              mode_nxt  = M_END;
              state_nxt = S_POP_RD;
            end
            default: ;
          endcase
        end
      end

      S_PUSH: begin
        if (count_r >= STACK_CAP) begin
          if (can_put) begin
            put           = 1'b1;
            put_item.kind = OUT_ERROR;
            state_nxt     = S_FLUSH;
          end
        end else begin
          req.wr_en   = 1'b1;
          req.wr_addr = count_r;
          req.wr_data = entry_r;
          count_nxt   = count_r + addr_t'(1);
          state_nxt   = S_FLUSH;
        end
      end

      // writes happen only in S_PUSH, which always passes through S_FLUSH and S_IDLE before any read
      S_POP_RD: begin
        if (count_r == '0) begin
          unique case (mode_r)
            M_OPER:   state_nxt = S_PUSH;
            M_RPAREN: state_nxt = S_FLUSH;
            M_END: begin
              if (can_put) begin
                put           = 1'b1;
                put_item.kind = OUT_END;
                state_nxt     = S_FLUSH;
              end
            end
            default: state_nxt = S_FLUSH;
          endcase
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = count_r - addr_t'(1);
          state_nxt   = S_POP_CHK;
        end
      end

      S_POP_CHK: begin
        unique case (mode_r)
          M_OPER: begin
            if (top == ENTRY_LPAREN || !pops) begin
              state_nxt = S_PUSH;
            end else if (can_put) begin
              put       = 1'b1;
              put_item  = entry_item(top);
              count_nxt = count_r - addr_t'(1);
              state_nxt = S_POP_RD;
            end
          end
          M_RPAREN: begin
            if (top == ENTRY_LPAREN) begin
              count_nxt = count_r - addr_t'(1);
              state_nxt = S_FLUSH;
            end else if (can_put) begin
              put       = 1'b1;
              put_item  = entry_item(top);
              count_nxt = count_r - addr_t'(1);
              state_nxt = S_POP_RD;
            end
          end
          M_END: begin
            if (top == ENTRY_LPAREN) begin
              count_nxt = count_r - addr_t'(1);
              state_nxt = S_POP_RD;
            end else if (can_put) begin
              put       = 1'b1;
              put_item  = entry_item(top);
              count_nxt = count_r - addr_t'(1);
              state_nxt = S_POP_RD;
            end
          end
          default: state_nxt = S_FLUSH;
        endcase
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (ofree) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = pend_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // the newest item waits in pend until it is known whether it is the last
    if (put) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = pend_r;
        out_last_nxt  = 1'b0;
      end
      pend_nxt   = put_item;
      pend_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_OPER;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    entry_r    <= entry_nxt;
    pend_r     <= pend_nxt;
    out_item_r <= out_item_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_item_r.kind;
  assign out_tdata  = {1'b0, out_item_r.number, out_item_r.word, out_item_r.op};
  assign out_tlast  = out_last_r;

endmodule

@@ src/ittp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ittp_checker
// Port-level checks for the infix-to-postfix token reorder core.
// ----------------------------------------------------------------------------
module ittp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import ittp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("out item changed while stalled");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == KIND_NUMBER |=> !in_tready)
    else $error("new item taken while a number is in flight");

  a_final_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == OUT_NUMBER || out_tuser == OUT_ERROR ||
                   out_tuser == OUT_END) |-> out_tlast)
    else $error("number, error or end item not marked last");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out valid after reset");

endmodule

bind infix_to_postfix_token_reorder_core ittp_checker u_ittp_checker (.*);
